>>> sv/skr_pkg.sv
// ----------------------------------------------------------------------------
// skr_pkg: shared types and constants of the scalar Kalman rate fusion unit
// Widths of the variance path, the long divider and the configuration port.
// ----------------------------------------------------------------------------
package skr_pkg;

    // Variances are unsigned Q16.16.
    localparam int VAR_W = 32;
    localparam logic [VAR_W-1:0] VAR_RESET = 32'd65536000;        // 1000.0
    localparam logic [VAR_W-1:0] MOTION_VAR_RESET = 32'd262144;   // 4.0
    localparam logic [VAR_W-1:0] MEAS_VAR_RESET = 32'd32768;      // 0.5

    // Configuration register indexes.
    localparam int IDX_W = 1;
    localparam logic [IDX_W-1:0] REG_MOTION_VAR = 1'b0;
    localparam logic [IDX_W-1:0] REG_MEAS_VAR = 1'b1;

    // Item kinds.
    localparam logic FUNC_GYRO = 1'b0;
    localparam logic FUNC_ODOM = 1'b1;

    // Multiplier operands are 33-bit signed, products 66-bit signed.
    localparam int OPD_W = VAR_W + 1;
    localparam int PRD_W = 2 * OPD_W;

    // The divider takes a 66-bit dividend, a 33-bit divisor and yields
    // a 32-bit quotient, one bit per cycle.
    localparam int DVD_W = PRD_W;
    localparam int DEN_W = VAR_W + 1;
    localparam int QUO_W = VAR_W;
    localparam int CNT_W = $clog2(QUO_W);

    typedef logic [OPD_W-1:0] skr_opd_t;
    typedef logic [PRD_W-1:0] skr_prd_t;
    typedef logic [DVD_W-1:0] skr_dvd_t;
    typedef logic [DEN_W-1:0] skr_den_t;
    typedef logic [QUO_W-1:0] skr_quo_t;

    typedef struct packed {
        logic     start;
        skr_dvd_t dividend;
        skr_den_t divisor;
    } skr_div_req_t;

    typedef struct packed {
        logic     done;
        skr_quo_t quotient;
    } skr_div_rsp_t;

endpackage

>>> sv/skr_in_if.sv
// ----------------------------------------------------------------------------
// skr_in_if: sample channel of the scalar Kalman rate fusion unit
// Carries one gyro or odometry yaw rate per beat.
// ----------------------------------------------------------------------------
interface skr_in_if #(
    parameter int RATE_WIDTH = 24
) ();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [RATE_WIDTH-1:0] rate_sample;

    modport source (output valid, output func, output rate_sample, input ready);
    modport sink (input valid, input func, input rate_sample, output ready);
endinterface

>>> sv/skr_out_if.sv
// ----------------------------------------------------------------------------
// skr_out_if: result channel of the scalar Kalman rate fusion unit
// Carries one fused rate and its variance per beat.
// ----------------------------------------------------------------------------
interface skr_out_if #(
    parameter int RATE_WIDTH = 24
) ();
    logic                  valid;
    logic                  ready;
    logic [RATE_WIDTH-1:0] filtered_rate;
    logic [31:0]           estimate_variance;

    modport source (output valid, output filtered_rate, output estimate_variance,
                    input ready);
    modport sink (input valid, input filtered_rate, input estimate_variance,
                  output ready);
endinterface

>>> sv/skr_div.sv
// ----------------------------------------------------------------------------
// skr_div: radix-2 restoring divider, one quotient bit per cycle
// The upper dividend bits must already be below the divisor, so the
// quotient fits QUO_W bits.
// ----------------------------------------------------------------------------
module skr_div
    import skr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  skr_div_req_t req,
    output skr_div_rsp_t rsp
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign trial = {rem_reg, quo_reg[QUO_W-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend[QUO_W+DEN_W-1:QUO_W];
            quo_reg <= req.dividend[QUO_W-1:0];
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DEN_W-2:0], quo_reg[QUO_W-1]};
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> sv/scalar_kalman_rate_fusion_unit.sv
// ----------------------------------------------------------------------------
// scalar_kalman_rate_fusion_unit: scalar Kalman filter on yaw rate
// Fuses wheel-odometry rate with gyro rate through a shared multiplier and
// a shared bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// A gyro beat or the first odometry beat is absorbed while the sequencer
// stays idle. An update beat yields its result after two passes through
// the one-bit-per-cycle divider, estimate then variance; with a zero
// denominator both passes are skipped. A new beat is taken only once the
// last result has been loaded, which waits while an earlier result is still
// held; the sample channel is not ready while an update runs. Reset is
// asynchronous, active low, and loads the register defaults and the filter's
// initial state at once.
// ----------------------------------------------------------------------------
module scalar_kalman_rate_fusion_unit
    import skr_pkg::*;
#(
    parameter int RATE_WIDTH = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    skr_in_if.sink           sample,
    skr_out_if.source        result,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [VAR_W-1:0] wr_data
);

    localparam int RW = RATE_WIDTH;
    localparam logic [RW-1:0] RATE_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic [RW-1:0] RATE_MIN = {1'b1, {(RW-1){1'b0}}};

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL_A  = 4'd1;
    localparam logic [3:0] ST_MUL_B  = 4'd2;
    localparam logic [3:0] ST_MUL_C  = 4'd3;
    localparam logic [3:0] ST_ABS    = 4'd4;
    localparam logic [3:0] ST_DIV_E  = 4'd5;
    localparam logic [3:0] ST_WAIT_E = 4'd6;
    localparam logic [3:0] ST_DIV_V  = 4'd7;
    localparam logic [3:0] ST_WAIT_V = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    // Configuration registers.
    logic [VAR_W-1:0] motion_var_reg;
    logic [VAR_W-1:0] meas_var_reg;

    // Filter state.
    logic [RW-1:0]    estimate_reg;
    logic [VAR_W-1:0] variance_reg;
    logic [RW-1:0]    gyro_reg;
    logic [RW-1:0]    prev_odom_reg;
    logic             awaiting_reg;

    // Working registers of one update.
    logic [3:0]       state_reg;
    logic [RW-1:0]    est_new_reg;
    logic [VAR_W-1:0] var_new_reg;
    skr_prd_t         prod_reg;
    skr_prd_t         num_reg;
    skr_dvd_t         dvd_reg;
    logic             neg_reg;

    // Output register.
    logic             out_valid_reg;
    logic [RW-1:0]    out_rate_reg;
    logic [VAR_W-1:0] out_var_reg;

    logic             accept;
    logic             load_out;
    logic [RW+1:0]    pred_sum;
    logic [RW-1:0]    pred_sat;
    logic [VAR_W:0]   var_sum;
    logic [VAR_W-1:0] var_pred;
    skr_den_t         den;
    skr_dvd_t         den_half;
    skr_opd_t         mul_a;
    skr_opd_t         mul_b;
    logic signed [PRD_W-1:0] mul_p;
    logic [QUO_W+1:0] quo_signed;
    logic [RW-1:0]    quo_sat;
    skr_div_req_t     div_req;
    skr_div_rsp_t     div_rsp;

    assign accept   = sample.valid && sample.ready;
    assign load_out = !out_valid_reg || result.ready;

    // Prediction: estimate plus the odometry rate change, saturated to the
    // rate range. Two guard bits hold the exact sum.
    assign pred_sum = {{2{estimate_reg[RW-1]}}, estimate_reg}
                    + {{2{sample.rate_sample[RW-1]}}, sample.rate_sample}
                    - {{2{prev_odom_reg[RW-1]}}, prev_odom_reg};

    always_comb
    begin
        if (&pred_sum[RW+1:RW-1] || !(|pred_sum[RW+1:RW-1]))
        begin
            pred_sat = pred_sum[RW-1:0];
        end
        else if (pred_sum[RW+1])
        begin
            pred_sat = RATE_MIN;
        end
        else
        begin
            pred_sat = RATE_MAX;
        end
    end

    // Predicted variance saturates at the top of the Q16.16 range.
    assign var_sum  = {1'b0, variance_reg} + {1'b0, motion_var_reg};
    assign var_pred = var_sum[VAR_W] ? {VAR_W{1'b1}} : var_sum[VAR_W-1:0];

    // Denominator P + R is exact on 33 bits. Adding half of it to the
    // dividend turns the truncating divider into round-to-nearest, which
    // matches both rounding rules of the update.
    assign den      = {1'b0, var_new_reg} + {1'b0, meas_var_reg};
    assign den_half = {{(DVD_W-DEN_W+1){1'b0}}, den[DEN_W-1:1]};

    // Shared signed multiplier; operand selection follows the sequencer.
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_A:
            begin
                mul_a = {1'b0, meas_var_reg};
                mul_b = {{(OPD_W-RW){est_new_reg[RW-1]}}, est_new_reg};
            end
            ST_MUL_B:
            begin
                mul_a = {1'b0, var_new_reg};
                mul_b = {{(OPD_W-RW){gyro_reg[RW-1]}}, gyro_reg};
            end
            default:
            begin
                mul_a = {1'b0, var_new_reg};
                mul_b = {1'b0, meas_var_reg};
            end
        endcase
    end

    assign mul_p = $signed(mul_a) * $signed(mul_b);

    // Signed estimate from the quotient magnitude, saturated to the rate
    // range (the weighted mean normally stays inside it).
    assign quo_signed = neg_reg ? ((QUO_W+2)'(0) - {2'b00, div_rsp.quotient})
                                : {2'b00, div_rsp.quotient};

    always_comb
    begin
        if (&quo_signed[QUO_W+1:RW-1] || !(|quo_signed[QUO_W+1:RW-1]))
        begin
            quo_sat = quo_signed[RW-1:0];
        end
        else if (quo_signed[QUO_W+1])
        begin
            quo_sat = RATE_MIN;
        end
        else
        begin
            quo_sat = RATE_MAX;
        end
    end

    // Divider requests: the estimate pass divides |R*est + P*gyro|, the
    // variance pass divides P*R, both by P + R.
    always_comb
    begin
        div_req.start    = (state_reg == ST_DIV_E) || (state_reg == ST_DIV_V);
        div_req.divisor  = den;
        div_req.dividend = (state_reg == ST_DIV_V) ? (prod_reg + den_half)
                                                   : (dvd_reg + den_half);
    end

    skr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_var_reg <= MOTION_VAR_RESET;
            meas_var_reg   <= MEAS_VAR_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MOTION_VAR: motion_var_reg <= wr_data;
                REG_MEAS_VAR:   meas_var_reg   <= wr_data;
                default:        ;
            endcase
        end
    end

    // Result beat flag: set when an update commits, cleared once the beat
    // is taken. A commit in the same cycle as a take keeps it set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Sequencer and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            estimate_reg  <= '0;
            variance_reg  <= VAR_RESET;
            gyro_reg      <= '0;
            prev_odom_reg <= '0;
            awaiting_reg  <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (sample.func == FUNC_GYRO)
                        begin
                            gyro_reg <= sample.rate_sample;
                        end
                        else if (awaiting_reg)
                        begin
                            // First odometry beat only seeds the filter.
                            estimate_reg  <= sample.rate_sample;
                            prev_odom_reg <= sample.rate_sample;
                            awaiting_reg  <= 1'b0;
                        end
                        else
                        begin
                            prev_odom_reg <= sample.rate_sample;
                            state_reg     <= ST_MUL_A;
                        end
                    end
                end
                ST_MUL_A:
                begin
                    // A zero denominator skips the update and keeps the
                    // prediction.
                    state_reg <= (den == '0) ? ST_DONE : ST_MUL_B;
                end
                ST_MUL_B:  state_reg <= ST_MUL_C;
                ST_MUL_C:  state_reg <= ST_ABS;
                ST_ABS:    state_reg <= ST_DIV_E;
                ST_DIV_E:  state_reg <= ST_WAIT_E;
                ST_WAIT_E:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_DIV_V;
                    end
                end
                ST_DIV_V:  state_reg <= ST_WAIT_V;
                ST_WAIT_V:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // Waits here only while an earlier result is still held.
                    if (load_out)
                    begin
                        estimate_reg  <= est_new_reg;
                        variance_reg  <= var_new_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers of the update.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                est_new_reg <= pred_sat;
                var_new_reg <= var_pred;
            end
            ST_MUL_A:
            begin
                prod_reg <= skr_prd_t'(mul_p);
            end
            ST_MUL_B:
            begin
                num_reg  <= prod_reg;
                prod_reg <= skr_prd_t'(mul_p);
            end
            ST_MUL_C:
            begin
                num_reg  <= num_reg + prod_reg;
                prod_reg <= skr_prd_t'(mul_p);
            end
            ST_ABS:
            begin
                neg_reg <= num_reg[PRD_W-1];
                dvd_reg <= num_reg[PRD_W-1] ? (DVD_W'(0) - num_reg) : num_reg;
            end
            ST_WAIT_E:
            begin
                if (div_rsp.done)
                begin
                    est_new_reg <= quo_sat;
                end
            end
            ST_WAIT_V:
            begin
                if (div_rsp.done)
                begin
                    var_new_reg <= div_rsp.quotient;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_rate_reg <= est_new_reg;
                    out_var_reg  <= var_new_reg;
                end
            end
            default: ;
        endcase
    end

    assign sample.ready             = (state_reg == ST_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.filtered_rate     = out_rate_reg;
    assign result.estimate_variance = out_var_reg;

endmodule

>>> sv/skr_checker.sv
// ----------------------------------------------------------------------------
// skr_checker: port-level checks of the scalar Kalman rate fusion unit
// Watches both channels and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module skr_checker #(
    parameter int RATE_WIDTH = 24
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  in_func,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [RATE_WIDTH-1:0] out_rate,
    input logic [31:0]           out_var
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rate) && $stable(out_var))
        else $error("result beat changed while stalled");

    // A result appears only at the end of an update, while samples were held off.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a preceding update");

    // A gyro beat is absorbed at once.
    a_gyro_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_func |=> in_ready)
        else $error("gyro beat stalled the sample channel");

    // No result is produced in the cycle right after a sample beat.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared one cycle after a sample beat");

endmodule

bind scalar_kalman_rate_fusion_unit skr_checker #(.RATE_WIDTH(RATE_WIDTH)) u_skr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_func   (sample.func),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_rate  (result.filtered_rate),
    .out_var   (result.estimate_variance)
);
